// ----- hdl/tas_pkg.sv -----
// Package: request/result types, mode and event codes, and defaults for the sequencer.
package tas_pkg;

  localparam int MAX_SLOTS_DEF = 10;

  localparam logic [2:0] MODE_TICK  = 3'd0;
  localparam logic [2:0] MODE_RUN   = 3'd1;
  localparam logic [2:0] MODE_STOP  = 3'd2;
  localparam logic [2:0] MODE_CLEAR = 3'd3;
  localparam logic [2:0] MODE_ADD   = 3'd4;

  localparam logic [2:0] EV_NONE     = 3'd0;
  localparam logic [2:0] EV_START    = 3'd1;
  localparam logic [2:0] EV_STOP     = 3'd2;
  localparam logic [2:0] EV_UPDATE   = 3'd3;
  localparam logic [2:0] EV_FINISHED = 3'd4;

  typedef struct packed {
    logic [2:0]  mode;
    logic [3:0]  start_slot;
    logic [15:0] interval_ms;
    logic [15:0] duration_ms;
  } tas_req_t;

  typedef struct packed {
    logic [2:0] event_res;
    logic [3:0] action_slot;
    logic       sequence_running;
    logic [3:0] slot_count;
  } tas_res_t;

endpackage

// ----- hdl/tas_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module tas_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- hdl/tas_seq.sv -----
// Sequencer state, slot table, single-pass request step and result register.
module tas_seq #(
  parameter int MAX_SLOTS = tas_pkg::MAX_SLOTS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  input  tas_pkg::tas_req_t req_q,
  input  logic              loop_enable,
  output logic              done,
  output tas_pkg::tas_res_t res
);
  import tas_pkg::*;

  localparam int CNT_W = $clog2(MAX_SLOTS + 1);
  localparam int CUR_W = (CNT_W > 4) ? CNT_W : 4;
  localparam int AW    = $clog2(MAX_SLOTS);

  logic [CNT_W-1:0] entries, entries_next;
  logic [CUR_W-1:0] current_slot, current_slot_next;
  logic             running, running_next;
  logic             slot_active, slot_active_next;
  logic [31:0]      elapsed_ticks, elapsed_ticks_next;
  logic [15:0]      wait0;
  logic             byp_hit;
  logic [31:0]      byp_data;
  logic [31:0]      ram_rdata;
  logic [31:0]      slot_data;
  logic             wr;
  tas_res_t         res_next;

  tas_ram #(.WIDTH(32), .DEPTH(MAX_SLOTS)) u_table (
    .clk   (clk),
    .we    (wr),
    .waddr (AW'(entries)),
    .wdata ({req_q.interval_ms, req_q.duration_ms}),
    .raddr (AW'(current_slot_next)),
    .rdata (ram_rdata)
  );

  assign slot_data = byp_hit ? byp_data : ram_rdata;

  always_comb begin
    logic [31:0]      el_inc;
    logic [CUR_W-1:0] ent_x;
    logic [CUR_W-1:0] cur_eff;
    logic [CUR_W-1:0] slot;
    logic [15:0]      wait_v;
    logic             wrap;
    logic             fin;
    entries_next       = entries;
    current_slot_next  = current_slot;
    running_next       = running;
    slot_active_next   = slot_active;
    elapsed_ticks_next = elapsed_ticks;
    wr                 = 1'b0;
    res_next.event_res = EV_NONE;
    slot               = '0;
    wrap               = 1'b0;
    fin                = 1'b0;
    el_inc  = (elapsed_ticks == 32'hFFFF_FFFF) ? elapsed_ticks : elapsed_ticks + 32'd1;
    ent_x   = CUR_W'(entries);
    cur_eff = current_slot;
    wait_v  = slot_data[31:16];
    if (req_valid) begin
      case (req_q.mode)
        MODE_TICK: begin
          if (running) begin
            elapsed_ticks_next = el_inc;
            if (!slot_active) begin
              if (current_slot >= ent_x) begin
                if (loop_enable && (entries != '0)) begin
                  wrap              = 1'b1;
                  current_slot_next = '0;
                end else begin
                  fin                = 1'b1;
                  running_next       = 1'b0;
                  res_next.event_res = EV_FINISHED;
                end
              end
              if (wrap) begin
                cur_eff = '0;
                wait_v  = wait0;
              end
              if (!fin && (cur_eff < CUR_W'(MAX_SLOTS)) && (el_inc > {16'd0, wait_v})) begin
                slot_active_next   = 1'b1;
                elapsed_ticks_next = '0;
                res_next.event_res = EV_START;
                slot               = cur_eff;
              end
            end else if (current_slot < CUR_W'(MAX_SLOTS)) begin
              slot = current_slot;
              if (el_inc > {16'd0, slot_data[15:0]}) begin
                slot_active_next   = 1'b0;
                current_slot_next  = current_slot + 1'b1;
                elapsed_ticks_next = '0;
                res_next.event_res = EV_STOP;
              end else begin
                res_next.event_res = EV_UPDATE;
              end
            end else begin
              slot_active_next = 1'b0;
            end
          end
        end
        MODE_RUN: begin
          if (!running) begin
            running_next       = 1'b1;
            elapsed_ticks_next = '0;
            current_slot_next  = CUR_W'(req_q.start_slot);
          end
        end
        MODE_STOP: begin
          if (running) begin
            running_next      = 1'b0;
            slot_active_next  = 1'b0;
            current_slot_next = '0;
          end
        end
        MODE_CLEAR: begin
          if (!running) begin
            current_slot_next = '0;
            entries_next      = '0;
          end
        end
        MODE_ADD: begin
          if (entries < CNT_W'(MAX_SLOTS)) begin
            wr           = 1'b1;
            entries_next = entries + 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
    res_next.action_slot      = slot[3:0];
    res_next.sequence_running = running_next;
    res_next.slot_count       = 4'(entries_next);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      entries       <= '0;
      current_slot  <= '0;
      running       <= 1'b0;
      slot_active   <= 1'b0;
      elapsed_ticks <= '0;
      done          <= 1'b0;
      byp_hit       <= 1'b0;
    end else begin
      entries       <= entries_next;
      current_slot  <= current_slot_next;
      running       <= running_next;
      slot_active   <= slot_active_next;
      elapsed_ticks <= elapsed_ticks_next;
      done          <= req_valid;
      byp_hit       <= wr && (AW'(entries) == AW'(current_slot_next));
    end
  end

  always_ff @(posedge clk) begin
    byp_data <= {req_q.interval_ms, req_q.duration_ms};
    res      <= res_next;
    if (wr && (entries == '0)) begin
      wait0 <= req_q.interval_ms;
    end
  end

endmodule

// ----- hdl/timed_action_sequencer.sv -----
// Top level of the timed action sequencer: request register, config register, sequencer core.
module timed_action_sequencer #(
  parameter int MAX_SLOTS = tas_pkg::MAX_SLOTS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  tas_pkg::tas_req_t req,
  output logic              done,
  output tas_pkg::tas_res_t res,
  input  logic              cfg_we,
  input  logic              cfg_wdata
);
  // Takes one request per clock cycle; busy stays low. Each request gives exactly
  // one result, strobed by done after the request register and then the single-pass
  // step into the result register. The result cannot be stalled.
  // Slot values come from a table RAM whose read is prefetched for the next slot.
  import tas_pkg::*;

  logic     req_valid;
  tas_req_t req_q;
  logic     loop_enable;

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      req_valid   <= 1'b0;
      loop_enable <= 1'b0;
    end else begin
      req_valid <= start && !busy;
      if (cfg_we) begin
        loop_enable <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    req_q <= req;
  end

  tas_seq #(.MAX_SLOTS(MAX_SLOTS)) u_seq (
    .clk         (clk),
    .rst         (rst),
    .req_valid   (req_valid),
    .req_q       (req_q),
    .loop_enable (loop_enable),
    .done        (done),
    .res         (res)
  );

`ifndef NO_ASSERTIONS
  a_latency: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> ##1 done)
    else $error("result missing two cycles after request");

  a_count: assert property (@(posedge clk) disable iff (rst)
    done |-> (32'(res.slot_count) <= 32'(MAX_SLOTS)))
    else $error("slot count beyond table size");

  a_fin: assert property (@(posedge clk) disable iff (rst)
    (done && (res.event_res == EV_FINISHED)) |-> !res.sequence_running)
    else $error("finished while still running");

  a_slot_ev: assert property (@(posedge clk) disable iff (rst)
    (done && ((res.event_res == EV_START) || (res.event_res == EV_STOP) ||
              (res.event_res == EV_UPDATE))) |-> res.sequence_running)
    else $error("slot event while idle");
`endif

endmodule
